>>> rtl/xml_char_escaper_defines.svh
// ---------------------------------------------------------------------------
// xml_char_escaper_defines
// assertion macros shared by the escaper rtl
// ---------------------------------------------------------------------------
`ifndef XML_CHAR_ESCAPER_DEFINES_SVH
`define XML_CHAR_ESCAPER_DEFINES_SVH

// property holds at every clock outside reset
`define XCE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent at the next clock
`define XCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/xce_pkg.sv
// ---------------------------------------------------------------------------
// xce_pkg
// types, constants and helpers for the xml character escaper
// ---------------------------------------------------------------------------
`default_nettype none

package xce_pkg;

  localparam int CP_W    = 21;
  localparam int RUN_MAX = 6;
  localparam int LEN_W   = $clog2(RUN_MAX + 1);
  localparam int IDX_W   = $clog2(RUN_MAX);

  typedef logic [CP_W-1:0]  cp_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam cp_t CP_TAB      = cp_t'(8'h09);
  localparam cp_t CP_LF       = cp_t'(8'h0A);
  localparam cp_t CP_CR       = cp_t'(8'h0D);
  localparam cp_t CP_CTRL_MAX = cp_t'(8'h1F);

  localparam logic [7:0] GLYPH_DIGIT_BASE  = 8'h30;
  localparam logic [7:0] GLYPH_LETTER_BASE = 8'h37;

  // escaped sequence for one input code point
  typedef struct packed {
    cp_t [RUN_MAX-1:0] sym;
    len_t              len;
  } run_t;

  function automatic cp_t ch(input logic [7:0] c);
    return {{(CP_W-8){1'b0}}, c};
  endfunction

  // upper-case hex digit glyph
  function automatic cp_t hex_glyph(input logic [3:0] n);
    logic [7:0] g;
    g = {4'b0, n} + ((n < 4'd10) ? GLYPH_DIGIT_BASE : GLYPH_LETTER_BASE);
    return ch(g);
  endfunction

endpackage

`default_nettype wire

>>> rtl/xce_encode.sv
// ---------------------------------------------------------------------------
// xce_encode
// maps one code point to its escaped run of one to six code points
// ---------------------------------------------------------------------------
`default_nettype none

module xce_encode (
  input  var xce_pkg::cp_t  code_point,
  input  var logic          escape_quotes,
  output xce_pkg::run_t     run
);
  import xce_pkg::*;

  always_comb begin
    run = '0;
    run.sym[0] = code_point;
    run.len = len_t'(1);
    if (code_point == ch("&")) begin
      run.sym[0] = ch("&"); run.sym[1] = ch("a"); run.sym[2] = ch("m");
      run.sym[3] = ch("p"); run.sym[4] = ch(";");
      run.len = len_t'(5);
    end else if (code_point == ch("<")) begin
      run.sym[0] = ch("&"); run.sym[1] = ch("l"); run.sym[2] = ch("t");
      run.sym[3] = ch(";");
      run.len = len_t'(4);
    end else if (code_point == ch(">")) begin
      run.sym[0] = ch("&"); run.sym[1] = ch("g"); run.sym[2] = ch("t");
      run.sym[3] = ch(";");
      run.len = len_t'(4);
    end else if (code_point == CP_TAB || code_point == CP_LF || code_point == CP_CR) begin
      run.len = len_t'(1);
    end else if (code_point <= CP_CTRL_MAX) begin
      // numeric character reference
      run.sym[0] = ch("&"); run.sym[1] = ch("#"); run.sym[2] = ch("x");
      run.sym[3] = hex_glyph(code_point[7:4]);
      run.sym[4] = hex_glyph(code_point[3:0]);
      run.sym[5] = ch(";");
      run.len = len_t'(6);
    end else if (escape_quotes && code_point == ch("\"")) begin
      run.sym[0] = ch("&"); run.sym[1] = ch("q"); run.sym[2] = ch("u");
      run.sym[3] = ch("o"); run.sym[4] = ch("t"); run.sym[5] = ch(";");
      run.len = len_t'(6);
    end else if (escape_quotes && code_point == ch("'")) begin
      run.sym[0] = ch("&"); run.sym[1] = ch("a"); run.sym[2] = ch("p");
      run.sym[3] = ch("o"); run.sym[4] = ch("s"); run.sym[5] = ch(";");
      run.len = len_t'(6);
    end
  end

endmodule

`default_nettype wire

>>> rtl/xml_char_escaper.sv
// ---------------------------------------------------------------------------
// xml_char_escaper
// Streams code points and emits their xml-escaped form, one output code
// point per cycle while out_ready is high. Plain text, a run of one per
// word, thus flows at one word per cycle; an escaped word occupies the output
// serializer for its run of four to six code points, during which one more
// input word waits in the input register. Each word passes the input register
// and then the run register before output. No state is kept between words.
// ---------------------------------------------------------------------------
`default_nettype none
`include "xml_char_escaper_defines.svh"

module xml_char_escaper (
  input  var logic          clk,
  input  var logic          rst,
  input  var logic          in_valid,
  output logic              in_ready,
  input  var xce_pkg::cp_t  code_point,
  input  var logic          escape_quotes,
  output logic              out_valid,
  input  var logic          out_ready,
  output xce_pkg::cp_t      out_code_point,
  output logic              last
);
  import xce_pkg::*;

  logic hold_valid;
  cp_t  hold_cp;
  logic hold_quotes;

  run_t enc_run;
  run_t run_word;
  logic run_valid;
  idx_t idx;

  logic run_free;
  logic load_run;

  xce_encode u_encode (
    .code_point    (hold_cp),
    .escape_quotes (hold_quotes),
    .run           (enc_run)
  );

  assign last           = (idx == idx_t'(run_word.len - len_t'(1)));
  assign out_valid      = run_valid;
  assign out_code_point = run_word.sym[idx];
  assign run_free       = !run_valid || (out_ready && last);
  assign load_run       = hold_valid && run_free;
  assign in_ready       = !hold_valid || load_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      run_valid  <= 1'b0;
      idx        <= '0;
    end else begin
      if (in_ready) begin
        hold_valid <= in_valid;
      end
      if (run_free) begin
        run_valid <= hold_valid;
        idx       <= '0;
      end else if (out_ready) begin
        idx <= idx + idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_cp     <= code_point;
      hold_quotes <= escape_quotes;
    end
    if (load_run) begin
      run_word <= enc_run;
    end
  end

  `XCE_ASSERT(a_idx_in_run, !run_valid || ((run_word.len != '0) && (len_t'(idx) < run_word.len)), "index beyond run")
  `XCE_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !last, out_valid && (idx != '0), "run cut short")
  `XCE_ASSERT_NEXT(a_new_run_starts, out_valid && out_ready && last, idx == '0, "run does not restart at first word")
  `XCE_ASSERT(a_single_is_last, !(run_valid && (run_word.len == len_t'(1))) || last, "single word run without last")

endmodule

`default_nettype wire
